### rtl/core/dmi_pkg.sv
// Shared types and constants for the decimal machine interpreter.
package dmi_pkg;

  localparam int WORD_W   = 10;
  localparam int ADDR_W   = 10;
  localparam int LIMIT_W  = 24;
  localparam int COUNT_W  = 25;
  localparam int RF_IDX_W = 4;
  localparam int DIGIT_W  = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd1000000;
  localparam logic [WORD_W:0]    WORD_MOD    = 11'd1000;

  // floor(x / 1000) = (x * RECIP_1000) >> RECIP_SHIFT, exact for x < 6e6
  localparam logic [20:0] RECIP_1000  = 21'd1073742;
  localparam int          RECIP_SHIFT = 30;

  // request operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;

  // instruction codes (hundreds digit)
  localparam logic [DIGIT_W-1:0] I_JUMP  = 4'd0;
  localparam logic [DIGIT_W-1:0] I_HALT  = 4'd1;
  localparam logic [DIGIT_W-1:0] I_SET   = 4'd2;
  localparam logic [DIGIT_W-1:0] I_ADD   = 4'd3;
  localparam logic [DIGIT_W-1:0] I_MUL   = 4'd4;
  localparam logic [DIGIT_W-1:0] I_COPY  = 4'd5;
  localparam logic [DIGIT_W-1:0] I_RADD  = 4'd6;
  localparam logic [DIGIT_W-1:0] I_RMUL  = 4'd7;
  localparam logic [DIGIT_W-1:0] I_LOAD  = 4'd8;
  localparam logic [DIGIT_W-1:0] I_STORE = 4'd9;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_port_t;

  typedef struct packed {
    logic                we;
    logic [RF_IDX_W-1:0] waddr;
    logic [WORD_W-1:0]   wdata;
    logic [RF_IDX_W-1:0] raddr_a;
    logic [RF_IDX_W-1:0] raddr_b;
  } rf_port_t;

  typedef struct packed {
    logic [COUNT_W-1:0] executed_count;
    logic               timed_out;
  } result_t;

endpackage

### rtl/core/dmi_ifs.sv
// Handshake channel interfaces: command, result and configuration.
interface dmi_cmd_if import dmi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [ADDR_W-1:0] address;
  logic [WORD_W-1:0] word;
  modport source (output valid, operation, address, word, input ready);
  modport sink (input valid, operation, address, word, output ready);
endinterface

interface dmi_res_if import dmi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] executed_count;
  logic               timed_out;
  modport source (output valid, executed_count, timed_out, input ready);
  modport sink (input valid, executed_count, timed_out, output ready);
endinterface

interface dmi_cfg_if import dmi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/core/dmi_prog_mem.sv
// Program/data memory: one write port, one registered read port.
module dmi_prog_mem import dmi_pkg::*; #(
  parameter int DEPTH = 1000
) (
  input  logic              clk,
  input  mem_port_t         port,
  output logic [WORD_W-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr[AW-1:0]] <= port.wdata;
    end
    rdata <= mem[port.raddr[AW-1:0]];
  end

endmodule

### rtl/core/dmi_reg_file.sv
// Register file: one write port, two registered read ports.
module dmi_reg_file import dmi_pkg::*; #(
  parameter int DEPTH = 10
) (
  input  logic              clk,
  input  rf_port_t          port,
  output logic [WORD_W-1:0] rdata_a,
  output logic [WORD_W-1:0] rdata_b
);

  localparam int IW = $clog2(DEPTH);

  logic [WORD_W-1:0] regs [DEPTH];

  always_ff @(posedge clk) begin
    if (port.we) begin
      regs[port.waddr[IW-1:0]] <= port.wdata;
    end
    rdata_a <= regs[port.raddr_a[IW-1:0]];
    rdata_b <= regs[port.raddr_b[IW-1:0]];
  end

endmodule

### rtl/core/dmi_exec.sv
// Sequencer: clear sweep, word writes and the fetch/decode/execute loop.
module dmi_exec import dmi_pkg::*; #(
  parameter int MEMORY_WORDS   = 1000,
  parameter int REGISTER_COUNT = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         operation,
  input  logic [ADDR_W-1:0]  address,
  input  logic [WORD_W-1:0]  word,
  output logic               idle,
  input  logic [LIMIT_W-1:0] step_limit,
  output mem_port_t          mem_port,
  input  logic [WORD_W-1:0]  mem_rdata,
  output rf_port_t           rf_port,
  input  logic [WORD_W-1:0]  rf_rdata_a,
  input  logic [WORD_W-1:0]  rf_rdata_b,
  output result_t            res,
  output logic               res_valid,
  input  logic               res_free
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_WORD, S_DIGIT, S_EXEC, S_MULQ, S_MODW, S_LOAD, S_DONE
  } state_t;

  state_t              state;
  logic [ADDR_W-1:0]   pc;
  logic [ADDR_W-1:0]   clr_idx;
  logic                clr_report;
  logic [LIMIT_W-1:0]  done;
  logic [DIGIT_W-1:0]  h_q;
  logic [6:0]          rem_q;
  logic [DIGIT_W-1:0]  d_q;
  logic [DIGIT_W-1:0]  n_q;
  logic [19:0]         prod_q;
  logic [WORD_W-1:0]   q_q;

  logic [DIGIT_W-1:0]  w_hund;
  logic [6:0]          w_rem;
  logic [DIGIT_W-1:0]  d_dig;
  logic [DIGIT_W-1:0]  n_dig;
  logic [WORD_W:0]     sum_raw;
  logic [WORD_W:0]     sum_mod;
  logic [WORD_W-1:0]   mul_b;
  logic [19:0]         prod;
  logic [40:0]         quot_full;
  logic [19:0]         modw;
  logic [ADDR_W-1:0]   pc_inc;
  logic [WORD_W-1:0]   word_mod;

  function automatic logic [DIGIT_W-1:0] hundreds(input logic [WORD_W-1:0] w);
    logic [DIGIT_W-1:0] c;
    c = '0;
    for (int k = 1; k < 10; k++) begin
      if (w >= WORD_W'(k * 100)) c = c + 4'd1;
    end
    return c;
  endfunction

  function automatic logic [DIGIT_W-1:0] tens(input logic [6:0] r);
    logic [DIGIT_W-1:0] c;
    c = '0;
    for (int k = 1; k < 10; k++) begin
      if (r >= 7'(k * 10)) c = c + 4'd1;
    end
    return c;
  endfunction

  assign w_hund   = hundreds(mem_rdata);
  assign w_rem    = 7'(mem_rdata - ({6'd0, w_hund} * 10'd100));
  assign d_dig    = tens(rem_q);
  assign n_dig    = 4'(rem_q - ({3'd0, d_dig} * 7'd10));
  assign sum_raw  = {1'b0, rf_rdata_a}
                    + ((h_q == I_ADD) ? {7'd0, n_q} : {1'b0, rf_rdata_b});
  assign sum_mod  = (sum_raw >= WORD_MOD) ? sum_raw - WORD_MOD : sum_raw;
  assign mul_b    = (h_q == I_MUL) ? {6'd0, n_q} : rf_rdata_b;
  assign prod     = {10'd0, rf_rdata_a} * {10'd0, mul_b};
  assign quot_full = {21'd0, prod_q} * {20'd0, RECIP_1000};
  assign modw     = prod_q - ({10'd0, q_q} * 20'd1000);
  assign pc_inc   = (pc == ADDR_W'(MEMORY_WORDS - 1)) ? '0 : pc + 1'b1;
  assign word_mod = (word >= WORD_W'(1000)) ? word - WORD_W'(1000) : word;

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    mem_port.we    = 1'b0;
    mem_port.waddr = rf_rdata_b;
    mem_port.wdata = rf_rdata_a;
    mem_port.raddr = pc;
    case (state)
      S_CLEAR: begin
        mem_port.we    = 1'b1;
        mem_port.waddr = clr_idx;
        mem_port.wdata = '0;
      end
      S_IDLE: begin
        mem_port.waddr = address;
        mem_port.wdata = word_mod;
        mem_port.we    = start && (operation == OP_WRITE)
                         && (address < ADDR_W'(MEMORY_WORDS));
      end
      S_EXEC: begin
        mem_port.raddr = rf_rdata_b;
        mem_port.we    = (h_q == I_STORE);
      end
      default: ;
    endcase
  end

  always_comb begin
    rf_port.we      = 1'b0;
    rf_port.waddr   = d_q;
    rf_port.wdata   = '0;
    rf_port.raddr_a = d_dig;
    rf_port.raddr_b = n_dig;
    case (state)
      S_CLEAR: begin
        rf_port.we    = (clr_idx < ADDR_W'(REGISTER_COUNT));
        rf_port.waddr = clr_idx[RF_IDX_W-1:0];
      end
      S_EXEC: begin
        case (h_q)
          I_SET: begin
            rf_port.we    = 1'b1;
            rf_port.wdata = {6'd0, n_q};
          end
          I_ADD, I_RADD: begin
            rf_port.we    = 1'b1;
            rf_port.wdata = sum_mod[WORD_W-1:0];
          end
          I_COPY: begin
            rf_port.we    = 1'b1;
            rf_port.wdata = rf_rdata_b;
          end
          default: ;
        endcase
      end
      S_MODW: begin
        rf_port.we    = 1'b1;
        rf_port.wdata = modw[WORD_W-1:0];
      end
      S_LOAD: begin
        rf_port.we    = 1'b1;
        rf_port.wdata = mem_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      clr_report <= 1'b0;
      pc         <= '0;
      done       <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (clr_idx == ADDR_W'(MEMORY_WORDS - 1)) begin
            res   <= '0;
            state <= clr_report ? S_DONE : S_IDLE;
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            res <= '0;
            case (operation)
              OP_CLEAR: begin
                clr_idx    <= '0;
                clr_report <= 1'b1;
                state      <= S_CLEAR;
              end
              OP_RUN: begin
                pc    <= '0;
                done  <= '0;
                state <= S_FETCH;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_FETCH: state <= S_WORD;
        S_WORD: begin
          h_q   <= w_hund;
          rem_q <= w_rem;
          state <= S_DIGIT;
        end
        S_DIGIT: begin
          d_q <= d_dig;
          n_q <= n_dig;
          if (h_q == I_HALT) begin
            res.executed_count <= {1'b0, done} + 1'b1;
            res.timed_out      <= 1'b0;
            state              <= S_DONE;
          end else if (done >= step_limit) begin
            res.executed_count <= {1'b0, done};
            res.timed_out      <= 1'b1;
            state              <= S_DONE;
          end else begin
            done  <= done + 1'b1;
            pc    <= pc_inc;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          prod_q <= prod;
          case (h_q)
            I_MUL, I_RMUL: state <= S_MULQ;
            I_LOAD:        state <= S_LOAD;
            I_JUMP: begin
              if (rf_rdata_b != '0) pc <= rf_rdata_a;
              state <= S_FETCH;
            end
            default: state <= S_FETCH;
          endcase
        end
        S_MULQ: begin
          q_q   <= quot_full[RECIP_SHIFT +: WORD_W];
          state <= S_MODW;
        end
        S_MODW: state <= S_FETCH;
        S_LOAD: state <= S_FETCH;
        S_DONE: begin
          if (res_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> (pc < ADDR_W'(MEMORY_WORDS)))
    else $error("program counter out of range at fetch");

  a_mem_wr_range: assert property (@(posedge clk) disable iff (rst)
    mem_port.we |-> (mem_port.waddr < ADDR_W'(MEMORY_WORDS)))
    else $error("memory write beyond last word");

  a_done_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> (done <= step_limit))
    else $error("instruction count passed step limit");

  a_timeout_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res.timed_out) |-> (res.executed_count == {1'b0, step_limit}))
    else $error("timed-out run reports wrong count");

  a_step_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT && h_q != I_HALT && done < step_limit)
    |=> (done == $past(done) + 1'b1) && (state == S_EXEC))
    else $error("executed instruction not counted");

endmodule

### rtl/core/decimal_machine_interpreter_core.sv
// Top level: decimal machine interpreter with program memory, registers and result buffer.
//
//   channel  dir  payload                        accepted when
//   cmd      in   operation, address, word       cmd.valid & cmd.ready
//   res      out  executed_count, timed_out      res.valid & res.ready
//   cfg      in   data (step_limit)              cfg.valid & cfg.ready
//
// Each instruction passes through the fetch, word, digit and execute states; load adds
// a load state and the two multiplies add quotient and modulo states, since the reads of
// both memories are registered. A run ends at the halt/limit check in the digit state.
// Write and unused requests go from idle to done; clear sweeps one word a cycle.
// After reset the same sweep runs before cmd.ready rises.
// cmd is taken while a finished result still waits in the output register.
module decimal_machine_interpreter_core import dmi_pkg::*; #(
  parameter int MEMORY_WORDS   = 1000,
  parameter int REGISTER_COUNT = 10
) (
  input  logic      clk,
  input  logic      rst,
  dmi_cmd_if.sink   cmd,
  dmi_res_if.source res,
  dmi_cfg_if.sink   cfg
);

  logic [LIMIT_W-1:0] step_limit;
  mem_port_t          mem_port;
  rf_port_t           rf_port;
  logic [WORD_W-1:0]  mem_rdata;
  logic [WORD_W-1:0]  rf_rdata_a;
  logic [WORD_W-1:0]  rf_rdata_b;
  result_t            exec_res;
  logic               exec_valid;
  logic               exec_idle;
  logic               res_free;
  logic               out_valid;
  result_t            out_res;

  assign cfg.ready = 1'b1;
  assign cmd.ready = exec_idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_limit <= LIMIT_RESET;
    end else if (cfg.valid) begin
      step_limit <= cfg.data;
    end
  end

  // output register, refilled in the cycle it drains
  assign res_free           = !out_valid || res.ready;
  assign res.valid          = out_valid;
  assign res.executed_count = out_res.executed_count;
  assign res.timed_out      = out_res.timed_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_valid && res_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_valid && res_free) begin
      out_res <= exec_res;
    end
  end

  dmi_prog_mem #(.DEPTH(MEMORY_WORDS)) u_prog_mem (
    .clk   (clk),
    .port  (mem_port),
    .rdata (mem_rdata)
  );

  dmi_reg_file #(.DEPTH(REGISTER_COUNT)) u_reg_file (
    .clk     (clk),
    .port    (rf_port),
    .rdata_a (rf_rdata_a),
    .rdata_b (rf_rdata_b)
  );

  dmi_exec #(
    .MEMORY_WORDS   (MEMORY_WORDS),
    .REGISTER_COUNT (REGISTER_COUNT)
  ) u_exec (
    .clk        (clk),
    .rst        (rst),
    .start      (cmd.valid && cmd.ready),
    .operation  (cmd.operation),
    .address    (cmd.address),
    .word       (cmd.word),
    .idle       (exec_idle),
    .step_limit (step_limit),
    .mem_port   (mem_port),
    .mem_rdata  (mem_rdata),
    .rf_port    (rf_port),
    .rf_rdata_a (rf_rdata_a),
    .rf_rdata_b (rf_rdata_b),
    .res        (exec_res),
    .res_valid  (exec_valid),
    .res_free   (res_free)
  );

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the decimal machine interpreter core: directed table, then random programs.
module testbench;
  import dmi_pkg::*;

  localparam int MEM_WORDS   = 1000;
  localparam int REGS        = 10;
  localparam int RANDOM_REQS = 600;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int TAIL_CYCLES = 40;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

  typedef struct {
    bit                 set_limit;
    logic [1:0]         op;
    logic [ADDR_W-1:0]  addr;
    logic [LIMIT_W-1:0] value;     // request word, or the new step limit
    bit                 known;
    logic [COUNT_W-1:0] count;
    logic               timed_out;
  } row_t;

  logic clk;
  logic rst;

  dmi_cmd_if cmd_ch ();
  dmi_res_if res_ch ();
  dmi_cfg_if cfg_ch ();

  decimal_machine_interpreter_core dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  logic [WORD_W-1:0]  mirror_mem [MEM_WORDS];
  logic [WORD_W-1:0]  mirror_regs [REGS];
  logic [LIMIT_W-1:0] mirror_limit;
  result_t            awaited_tallies [$];
  row_t               plan [$];
  int                 errors = 0;
  int                 cycles = 0;
  int                 calm_left [2] = '{0, 0};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Applies one request to the shadow machine and returns its tally.
  function automatic result_t interpret_request(input logic [1:0] op,
                                                input logic [ADDR_W-1:0] a,
                                                input logic [WORD_W-1:0] w);
    result_t r;
    int      done;
    int      pc;
    int      instr;
    int      h;
    int      d;
    int      n;
    bit      stop;
    r = '0;
    case (op)
      OP_CLEAR: begin
        foreach (mirror_mem[i]) mirror_mem[i] = '0;
        foreach (mirror_regs[i]) mirror_regs[i] = '0;
      end
      OP_WRITE: begin
        if (a < MEM_WORDS) mirror_mem[a] = WORD_W'(int'(w) % 1000);
      end
      OP_RUN: begin
        done = 0;
        pc = 0;
        stop = 1'b0;
        while (!stop) begin
          instr = int'(mirror_mem[pc]);
          h = instr / 100;
          d = (instr / 10) % 10;
          n = instr % 10;
          if (h == I_HALT) begin
            r.executed_count = COUNT_W'(done + 1);
            stop = 1'b1;
          end else if (done >= int'(mirror_limit)) begin
            r.executed_count = COUNT_W'(done);
            r.timed_out = 1'b1;
            stop = 1'b1;
          end else begin
            done++;
            pc = (pc + 1) % MEM_WORDS;
            case (h)
              I_SET:   mirror_regs[d] = WORD_W'(n);
              I_ADD:   mirror_regs[d] = WORD_W'((int'(mirror_regs[d]) + n) % 1000);
              I_MUL:   mirror_regs[d] = WORD_W'((int'(mirror_regs[d]) * n) % 1000);
              I_COPY:  mirror_regs[d] = mirror_regs[n];
              I_RADD:  mirror_regs[d] =
                         WORD_W'((int'(mirror_regs[d]) + int'(mirror_regs[n])) % 1000);
              I_RMUL:  mirror_regs[d] =
                         WORD_W'((int'(mirror_regs[d]) * int'(mirror_regs[n])) % 1000);
              I_LOAD:  mirror_regs[d] = mirror_mem[mirror_regs[n]];
              I_STORE: mirror_mem[mirror_regs[n]] = mirror_regs[d];
              I_JUMP: begin
                if (mirror_regs[n] != 0) pc = int'(mirror_regs[d]);
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // side 0: request sender, side 1: result receiver
  function automatic int draw_wait(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic logic [WORD_W-1:0] random_instr(input bit straight);
    int h;
    if (straight) begin
      h = $urandom_range(2, 8);   // no halt, store or jump: cannot loop
    end else begin
      h = $urandom_range(0, 9);
      if (h == I_HALT && $urandom_range(0, 3) != 0) h = int'(I_SET);
    end
    return WORD_W'(h * 100 + $urandom_range(0, 99));
  endfunction

  function automatic row_t req(input logic [1:0] op, input int a, input int w,
                               input bit known = 1'b0, input int count = 0,
                               input bit tout = 1'b0);
    row_t r;
    r.set_limit = 1'b0;
    r.op = op;
    r.addr = ADDR_W'(a);
    r.value = LIMIT_W'(w);
    r.known = known;
    r.count = COUNT_W'(count);
    r.timed_out = tout;
    return r;
  endfunction

  function automatic row_t limit_row(input int v);
    row_t r;
    r = req(OP_CLEAR, 0, v);
    r.set_limit = 1'b1;
    return r;
  endfunction

  task automatic send_request(input logic [1:0] op, input int a,
                              input int w, input bit known = 1'b0,
                              input logic [COUNT_W-1:0] count = '0,
                              input logic tout = 1'b0);
    int      gap;
    result_t tally;
    gap = draw_wait(0);
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.operation <= op;
    cmd_ch.address   <= ADDR_W'(a);
    cmd_ch.word      <= WORD_W'(w);
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    tally = interpret_request(op, ADDR_W'(a), WORD_W'(w));
    if (known) begin
      tally.executed_count = count;
      tally.timed_out = tout;
    end
    awaited_tallies.push_back(tally);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (awaited_tallies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    mirror_limit = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : result_sink
    int      stall;
    result_t want;
    res_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = draw_wait(1);
      @(negedge clk);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid === 1'b1 && res_ch.ready === 1'b1));
      if (awaited_tallies.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: executed_count %0d timed_out %0b",
                 $time, res_ch.executed_count, res_ch.timed_out);
      end else begin
        want = awaited_tallies.pop_front();
        if (res_ch.executed_count !== want.executed_count) begin
          errors++;
          $display("%0t: executed_count expected %0d got %0d",
                   $time, want.executed_count, res_ch.executed_count);
        end
        if (res_ch.timed_out !== want.timed_out) begin
          errors++;
          $display("%0t: timed_out expected %0b got %0b",
                   $time, want.timed_out, res_ch.timed_out);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL decimal_machine_interpreter_core");
    $finish;
  end

  initial begin : stimulus
    int                 sent;
    int                 phase;
    int                 len;
    bit                 straight;
    logic [LIMIT_W-1:0] limit;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.operation = OP_CLEAR;
    cmd_ch.address = '0;
    cmd_ch.word = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    void'(interpret_request(OP_CLEAR, '0, '0));
    mirror_limit = LIMIT_RESET;

    plan.push_back(req(OP_WRITE, 0, 100));
    plan.push_back(req(OP_RUN, 0, 0, 1'b1, 1, 1'b0));         // lone halt, reset limit
    plan.push_back(limit_row(1));
    plan.push_back(req(OP_WRITE, 0, 205));
    plan.push_back(req(OP_WRITE, 1, 100));
    plan.push_back(req(OP_RUN, 0, 0));                        // halt runs past the limit
    plan.push_back(req(OP_WRITE, 1, 0));
    plan.push_back(req(OP_RUN, 1023, 1023, 1'b1, 1, 1'b1));   // stopped at the limit
    plan.push_back(limit_row(40));
    plan.push_back(req(OP_CLEAR, 0, 0, 1'b1, 0, 1'b0));
    plan.push_back(req(OP_UNUSED, 1023, 1023, 1'b1, 0, 1'b0));
    plan.push_back(req(OP_WRITE, 1023, 100, 1'b1, 0, 1'b0));  // out of range: dropped
    plan.push_back(req(OP_RUN, 0, 0, 1'b1, 40, 1'b1));        // zero memory never halts
    // all instruction kinds; 999 holds 1019 -> 019 and falls through to 0
    plan.push_back(req(OP_WRITE, 0, 289));
    plan.push_back(req(OP_WRITE, 1, 878));
    plan.push_back(req(OP_WRITE, 2, 251));
    plan.push_back(req(OP_WRITE, 3, 75));
    plan.push_back(req(OP_WRITE, 9, 993));
    plan.push_back(req(OP_WRITE, 993, 339));
    plan.push_back(req(OP_WRITE, 994, 553));
    plan.push_back(req(OP_WRITE, 995, 457));
    plan.push_back(req(OP_WRITE, 996, 655));
    plan.push_back(req(OP_WRITE, 997, 755));
    plan.push_back(req(OP_WRITE, 998, 958));
    plan.push_back(req(OP_WRITE, 999, 1019));
    plan.push_back(req(OP_RUN, 0, 0));
    plan.push_back(req(OP_WRITE, 876, 100));
    plan.push_back(req(OP_RUN, 0, 0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].set_limit) begin
        write_limit(plan[i].value);
      end else begin
        send_request(plan[i].op, int'(plan[i].addr), int'(plan[i].value[WORD_W-1:0]),
                     plan[i].known, plan[i].count, plan[i].timed_out);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_REQS) begin
      if (phase == 0) begin
        limit = LIMIT_MAX;
      end else if (phase == 1) begin
        limit = LIMIT_W'(1);
      end else begin
        case ($urandom_range(0, 9))
          0:       limit = LIMIT_W'(1);
          1:       limit = LIMIT_MAX;
          2:       limit = LIMIT_W'($urandom_range(2, 20));
          default: limit = LIMIT_W'($urandom_range(21, 300));
        endcase
      end
      phase++;
      // a huge limit only gets loop-free programs
      straight = (limit > 300);
      write_limit(limit);
      if (straight || $urandom_range(0, 2) == 0) begin
        send_request(OP_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023));
        sent++;
      end
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
      for (int i = 0; i < len; i++) begin
        send_request(OP_WRITE, i, int'(random_instr(straight)));
        sent++;
      end
      if (straight || $urandom_range(0, 4) != 0) begin
        send_request(OP_WRITE, len, 100 + $urandom_range(0, 99));
        sent++;
      end
      repeat ($urandom_range(0, 4)) begin
        send_request(OP_WRITE, $urandom_range(len + 1, 999), $urandom_range(0, 999));
        sent++;
      end
      repeat ($urandom_range(1, 4)) begin
        send_request(OP_RUN, $urandom_range(0, 1023), $urandom_range(0, 1023));
        sent++;
        if (!straight) begin
          repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 3))
              0: begin
                send_request(OP_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023));
                sent++;
              end
              1: begin
                send_request(OP_WRITE, $urandom_range(1000, 1023), $urandom_range(0, 1023));
                sent++;
              end
              2: begin
                send_request(OP_WRITE, $urandom_range(0, len), $urandom_range(0, 1023));
                sent++;
              end
              default: begin
                send_request(OP_WRITE, $urandom_range(0, 999), int'(random_instr(1'b0)));
                sent++;
              end
            endcase
          end
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS decimal_machine_interpreter_core");
    end else begin
      $display("FAIL decimal_machine_interpreter_core");
    end
    $finish;
  end

endmodule
